FILE: src/mp2_pkg.sv
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared types and constants for the rgb max pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2_pkg;

  localparam int CHANNELS    = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_KERNEL  = 8;
  localparam int MAX_WIDTH   = 1024;
  localparam int POS_BITS    = 10;
  localparam int KERN_BITS   = 4;
  localparam int DIM_BITS    = 11;
  localparam int STEP_BITS   = 5;
  localparam int ROW_SEL     = $clog2(MAX_KERNEL);
  localparam int ADDR_BITS   = ROW_SEL + $clog2(MAX_WIDTH);
  localparam int WORD_BITS   = CHANNELS * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_KERNEL = 2'd0;
  localparam reg_index_t REG_STRIDE = 2'd1;
  localparam reg_index_t REG_WIDTH  = 2'd2;
  localparam reg_index_t REG_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // raster position of the next pixel, with row and column split by stride
  typedef struct packed {
    logic [POS_BITS-1:0]  row;
    logic [POS_BITS-1:0]  col;
    logic [KERN_BITS-1:0] row_phase;
    logic [KERN_BITS-1:0] col_phase;
    logic [POS_BITS-1:0]  row_quot;
    logic [POS_BITS-1:0]  col_quot;
  } pos_t;

endpackage

`default_nettype wire

FILE: src/mp2_lane.sv
// ----------------------------------------------------------------------------
// mp2_lane
// One channel lane: running maximum update for a single sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2_lane (
  input  var mp2_pkg::sample_t sample,
  input  var mp2_pkg::sample_t stored,
  input  wire                  first,
  output mp2_pkg::sample_t     result
);

  // the first pixel of a window seeds the maximum
  always_comb begin
    if (first || (sample > stored)) begin
      result = sample;
    end else begin
      result = stored;
    end
  end

endmodule

`default_nettype wire

FILE: src/mp2_pos.sv
// ----------------------------------------------------------------------------
// mp2_pos
// Raster position tracker: row, column and their stride phase and quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2_pos (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              restart,
  input  wire                              advance,
  input  wire [mp2_pkg::KERN_BITS-1:0]     stride,
  input  wire [mp2_pkg::DIM_BITS-1:0]      width,
  input  wire [mp2_pkg::DIM_BITS-1:0]      height,
  output mp2_pkg::pos_t                    pos
);

  logic [mp2_pkg::DIM_BITS-1:0]  col_inc;
  logic [mp2_pkg::DIM_BITS-1:0]  row_inc;
  logic [mp2_pkg::STEP_BITS-1:0] col_ph_inc;
  logic [mp2_pkg::STEP_BITS-1:0] row_ph_inc;
  logic                          col_wrap;
  logic                          row_wrap;
  logic                          col_ph_wrap;
  logic                          row_ph_wrap;

  assign col_inc     = {1'b0, pos.col} + 11'd1;
  assign row_inc     = {1'b0, pos.row} + 11'd1;
  assign col_ph_inc  = {1'b0, pos.col_phase} + 5'd1;
  assign row_ph_inc  = {1'b0, pos.row_phase} + 5'd1;
  assign col_wrap    = (col_inc >= width);
  assign row_wrap    = (row_inc >= height);
  assign col_ph_wrap = (col_ph_inc == {1'b0, stride});
  assign row_ph_wrap = (row_ph_inc == {1'b0, stride});

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos <= '0;
    end else if (advance) begin
      if (!col_wrap) begin
        pos.col <= col_inc[mp2_pkg::POS_BITS-1:0];
        if (col_ph_wrap) begin
          pos.col_phase <= '0;
          pos.col_quot  <= pos.col_quot + 10'd1;
        end else begin
          pos.col_phase <= col_ph_inc[mp2_pkg::KERN_BITS-1:0];
        end
      end else begin
        pos.col       <= '0;
        pos.col_phase <= '0;
        pos.col_quot  <= '0;
        if (row_wrap) begin
          pos.row       <= '0;
          pos.row_phase <= '0;
          pos.row_quot  <= '0;
        end else begin
          pos.row <= row_inc[mp2_pkg::POS_BITS-1:0];
          if (row_ph_wrap) begin
            pos.row_phase <= '0;
            pos.row_quot  <= pos.row_quot + 10'd1;
          end else begin
            pos.row_phase <= row_ph_inc[mp2_pkg::KERN_BITS-1:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/max_pool_2d_rgb.sv
// ----------------------------------------------------------------------------
// max_pool_2d_rgb
// Streaming 2-d max pooling of three-channel pixels over square windows.
// ----------------------------------------------------------------------------
// Pixels are taken in raster order, one beat per pixel. Each pixel updates
// every open window that covers it, one window at a time through a
// read-modify-write of the window store (one port, registered read). A pixel
// whose row or column phase within the stride is at or above the kernel size
// is folded into no window; any other pixel walks its candidate window
// positions, up to ceil(kernel/stride) squared, each through a read state and
// then an update state, and holds off the next pixel until the walk ends.
// Positions whose window falls off the bottom or right edge are still walked,
// but not written. The final update of a window also waits while a pooled
// pixel already in the output register is stalled. The three channels are
// compared in parallel lanes. A pooled pixel leaves when the bottom-right
// pixel of its window has been folded in, frame_last marking the last of a
// frame. Any register write restarts the frame; write only when idle.
`default_nettype none

module max_pool_2d_rgb (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [10:0]           cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire signed [15:0]    chan_r,
  input  wire signed [15:0]    chan_g,
  input  wire signed [15:0]    chan_b,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic signed [15:0]   max_r,
  output logic signed [15:0]   max_g,
  output logic signed [15:0]   max_b,
  output logic                 frame_last
);

  localparam int CH = mp2_pkg::CHANNELS;
  localparam int SB = mp2_pkg::SAMPLE_BITS;

  logic [3:0]  kern_size;
  logic [3:0]  stride;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [3:0]  k_eff;
  logic [3:0]  s_eff;
  logic [10:0] w_eff;
  logic [10:0] h_eff;

  mp2_pkg::state_t state;
  mp2_pkg::state_t state_next;
  mp2_pkg::pos_t   pos;

  mp2_pkg::sample_t px [CH];
  mp2_pkg::sample_t stored [CH];
  mp2_pkg::sample_t lane_max [CH];

  logic [9:0] cur_row;
  logic [9:0] cur_col;
  logic [3:0] col_phase;
  logic [9:0] col_quot;
  logic [4:0] dy;
  logic [4:0] dx;
  logic [9:0] oy;
  logic [9:0] ox;

  logic [mp2_pkg::WORD_BITS-1:0] store [2**mp2_pkg::ADDR_BITS];
  logic [mp2_pkg::WORD_BITS-1:0] rdata;
  logic [mp2_pkg::WORD_BITS-1:0] wdata;
  logic [mp2_pkg::ADDR_BITS-1:0] addr;

  logic accept;
  logic start_ok;
  logic row_ok;
  logic col_ok;
  logic pair_ok;
  logic first;
  logic final_pair;
  logic last_flag;
  logic hold;
  logic [4:0] dx_step;
  logic [4:0] dy_step;
  logic more_col;
  logic more_row;
  logic mem_we;
  logic out_load;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      kern_size    <= 4'd2;
      stride       <= 4'd2;
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2_pkg::REG_KERNEL: kern_size    <= cfg_data[3:0];
        mp2_pkg::REG_STRIDE: stride       <= cfg_data[3:0];
        mp2_pkg::REG_WIDTH:  image_width  <= cfg_data;
        mp2_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_eff = (kern_size == 4'd0) ? 4'd1 : ((kern_size > 4'd8) ? 4'd8 : kern_size);
    s_eff = (stride == 4'd0) ? 4'd1 : stride;
    w_eff = (image_width == 11'd0) ? 11'd1 :
            ((image_width > 11'd1024) ? 11'd1024 : image_width);
    h_eff = (image_height == 11'd0) ? 11'd1 :
            ((image_height > 11'd1024) ? 11'd1024 : image_height);
  end

  assign in_stall = (state != mp2_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  mp2_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .advance (accept),
    .stride  (s_eff),
    .width   (w_eff),
    .height  (h_eff),
    .pos     (pos)
  );

  assign start_ok = (pos.row_phase < k_eff) && (pos.col_phase < k_eff);

  // window checks for the current (dy, dx) pair
  assign row_ok  = ({2'b0, cur_row} + {8'b0, k_eff}) <= ({1'b0, h_eff} + {7'b0, dy});
  assign col_ok  = ({2'b0, cur_col} + {8'b0, k_eff}) <= ({1'b0, w_eff} + {7'b0, dx});
  assign pair_ok = row_ok && col_ok;
  assign first   = (dy == 5'd0) && (dx == 5'd0);
  assign final_pair = pair_ok && (dy == {1'b0, k_eff - 4'd1}) &&
                      (dx == {1'b0, k_eff - 4'd1});
  assign last_flag  = (({2'b0, cur_row} + 12'd1 + {8'b0, s_eff}) > {1'b0, h_eff}) &&
                      (({2'b0, cur_col} + 12'd1 + {8'b0, s_eff}) > {1'b0, w_eff});
  assign hold     = final_pair && out_valid && out_stall;
  assign dx_step  = dx + {1'b0, s_eff};
  assign dy_step  = dy + {1'b0, s_eff};
  assign more_col = (dx_step < {1'b0, k_eff}) && ({5'b0, dx_step} <= cur_col);
  assign more_row = (dy_step < {1'b0, k_eff}) && ({5'b0, dy_step} <= cur_row);

  assign addr = {oy[mp2_pkg::ROW_SEL-1:0], ox};

  // channel lanes and merge into one store word
  for (genvar g = 0; g < CH; g++) begin : g_lane
    assign stored[g] = mp2_pkg::sample_t'(rdata[g*SB +: SB]);
    mp2_lane u_lane (
      .sample (px[g]),
      .stored (stored[g]),
      .first  (first),
      .result (lane_max[g])
    );
    assign wdata[g*SB +: SB] = lane_max[g];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mp2_pkg::ST_IDLE: begin
        if (accept && start_ok) begin
          state_next = mp2_pkg::ST_READ;
        end
      end
      mp2_pkg::ST_READ: begin
        state_next = mp2_pkg::ST_UPDATE;
      end
      mp2_pkg::ST_UPDATE: begin
        if (hold) begin
          state_next = mp2_pkg::ST_UPDATE;
        end else if (more_col || more_row) begin
          state_next = mp2_pkg::ST_READ;
        end else begin
          state_next = mp2_pkg::ST_IDLE;
        end
      end
      default: state_next = mp2_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      mp2_pkg::ST_UPDATE: begin
        mem_we   = pair_ok && !hold;
        out_load = final_pair && !hold;
      end
      default: begin
        mem_we   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mp2_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel and window walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px[0]     <= chan_r;
      px[1]     <= chan_g;
      px[2]     <= chan_b;
      cur_row   <= pos.row;
      cur_col   <= pos.col;
      col_phase <= pos.col_phase;
      col_quot  <= pos.col_quot;
      dy        <= {1'b0, pos.row_phase};
      dx        <= {1'b0, pos.col_phase};
      oy        <= pos.row_quot;
      ox        <= pos.col_quot;
    end else if ((state == mp2_pkg::ST_UPDATE) && !hold) begin
      if (more_col) begin
        dx <= dx_step;
        ox <= ox - 10'd1;
      end else if (more_row) begin
        dy <= dy_step;
        oy <= oy - 10'd1;
        dx <= {1'b0, col_phase};
        ox <= col_quot;
      end
    end
  end

  // window store, read then write back
  always_ff @(posedge clk) begin
    if (state == mp2_pkg::ST_READ) begin
      rdata <= store[addr];
    end
    if (mem_we) begin
      store[addr] <= wdata;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      max_r      <= lane_max[0];
      max_g      <= lane_max[1];
      max_b      <= lane_max[2];
      frame_last <= last_flag;
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames through max_pool_2d_rgb under several window and image
// settings, predicts every pooled pixel and checks the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    mp2_pkg::sample_t r;
    mp2_pkg::sample_t g;
    mp2_pkg::sample_t b;
  } pixel_t;

  typedef struct {
    mp2_pkg::sample_t r;
    mp2_pkg::sample_t g;
    mp2_pkg::sample_t b;
    logic             last;
  } pooled_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [10:0]      cfg_data;
  logic             in_valid;
  logic             in_stall;
  mp2_pkg::sample_t chan_r;
  mp2_pkg::sample_t chan_g;
  mp2_pkg::sample_t chan_b;
  logic             out_valid;
  logic             out_stall;
  mp2_pkg::sample_t max_r;
  mp2_pkg::sample_t max_g;
  mp2_pkg::sample_t max_b;
  logic             frame_last;

  max_pool_2d_rgb u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .chan_r(chan_r), .chan_g(chan_g), .chan_b(chan_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .max_r(max_r), .max_g(max_g), .max_b(max_b), .frame_last(frame_last)
  );

  // pooling model state
  mp2_pkg::sample_t window_acc[mp2_pkg::MAX_KERNEL][mp2_pkg::MAX_WIDTH][mp2_pkg::CHANNELS];
  logic [9:0]  row_pos;
  logic [9:0]  col_pos;
  logic [3:0]  kernel_reg;
  logic [3:0]  stride_reg;
  logic [10:0] width_reg;
  logic [10:0] height_reg;

  pixel_t  pixel_q[$];
  pooled_t pooled_q[$];
  int      fail_count;
  int      pixel_total;
  bit      quiet_mode;
  bit      hold_req;
  int      send_gap;
  int      stall_left;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void queue_pixel(pixel_t p);
    pixel_q = {pixel_q, p};
  endfunction

  function automatic void fold_pixel(pixel_t p);
    int               k, s, w, h, r, c, top, left, oy, ox;
    mp2_pkg::sample_t px[mp2_pkg::CHANNELS];
    pooled_t          res;
    k = clamp_dim(kernel_reg, mp2_pkg::MAX_KERNEL);
    s = clamp_dim(stride_reg, 15);
    w = clamp_dim(width_reg, mp2_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, 1024);
    r = row_pos;
    c = col_pos;
    px[0] = p.r;
    px[1] = p.g;
    px[2] = p.b;
    for (int dy = 0; dy < k && dy <= r; dy++) begin
      top = r - dy;
      if (top % s != 0 || top + k > h) continue;
      oy = (top / s) % mp2_pkg::MAX_KERNEL;
      for (int dx = 0; dx < k && dx <= c; dx++) begin
        left = c - dx;
        if (left % s != 0 || left + k > w) continue;
        ox = left / s;
        if (ox >= mp2_pkg::MAX_WIDTH) continue;
        for (int ch = 0; ch < mp2_pkg::CHANNELS; ch++) begin
          if ((dy == 0 && dx == 0) || px[ch] > window_acc[oy][ox][ch])
            window_acc[oy][ox][ch] = px[ch];
        end
        if (dy == k - 1 && dx == k - 1) begin
          res.r = window_acc[oy][ox][0];
          res.g = window_acc[oy][ox][1];
          res.b = window_acc[oy][ox][2];
          res.last = (top / s == (h - k) / s && ox == (w - k) / s);
          pooled_q = {pooled_q, res};
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c[9:0];
    row_pos = r[9:0];
  endfunction

  function automatic int pick_gap();
    int d;
    d = $urandom_range(0, 99);
    if (quiet_mode || d < 60) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // pixel driver
  always @(posedge clk) begin
    pixel_t nxt;
    bit     taken;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) fold_pixel('{chan_r, chan_g, chan_b});
      if (!in_valid || taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          chan_r <= nxt.r;
          chan_g <= nxt.g;
          chan_b <= nxt.b;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    pooled_t exp_px;
    int      d;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pooled_q.size() == 0) begin
          $error("pooled beat with nothing expected");
          fail_count++;
        end else begin
          exp_px = pooled_q.pop_front();
          if (max_r !== exp_px.r) begin
            $error("max_r expected %0d got %0d", exp_px.r, max_r);
            fail_count++;
          end
          if (max_g !== exp_px.g) begin
            $error("max_g expected %0d got %0d", exp_px.g, max_g);
            fail_count++;
          end
          if (max_b !== exp_px.b) begin
            $error("max_b expected %0d got %0d", exp_px.b, max_b);
            fail_count++;
          end
          if (frame_last !== exp_px.last) begin
            $error("frame_last expected %0b got %0b", exp_px.last, frame_last);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left <= 599;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        d = $urandom_range(0, 99);
        if (quiet_mode || d < 70) begin
          out_stall <= 1'b0;
        end else if (d < 95) begin
          stall_left <= $urandom_range(0, 3);
          out_stall <= 1'b1;
        end else begin
          stall_left <= $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || pooled_q.size() > 0) @(posedge clk);
    // a pixel that pools nothing may still be folding into the store
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(mp2_pkg::reg_index_t idx, logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mp2_pkg::REG_KERNEL: kernel_reg = val[3:0];
      mp2_pkg::REG_STRIDE: stride_reg = val[3:0];
      mp2_pkg::REG_WIDTH:  width_reg = val;
      default:             height_reg = val;
    endcase
    row_pos = '0;
    col_pos = '0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int k, int s, int w, int h);
    wait_idle();
    write_reg(mp2_pkg::REG_KERNEL, 11'(k));
    write_reg(mp2_pkg::REG_STRIDE, 11'(s));
    write_reg(mp2_pkg::REG_WIDTH, 11'(w));
    write_reg(mp2_pkg::REG_HEIGHT, 11'(h));
  endtask

  function automatic mp2_pkg::sample_t rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return mp2_pkg::sample_t'($urandom_range(0, 15)) - 16'sd8;
      default: return mp2_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic push_pixels(int n);
    for (int i = 0; i < n; i++) begin
      queue_pixel('{rand_sample(), rand_sample(), rand_sample()});
      pixel_total++;
    end
  endtask

  initial begin
    int k, s, w, h, n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mp2_pkg::REG_KERNEL;
    cfg_data = '0;
    in_valid = 1'b0;
    chan_r = '0;
    chan_g = '0;
    chan_b = '0;
    out_stall = 1'b0;
    fail_count = 0;
    pixel_total = 0;
    quiet_mode = 1'b0;
    hold_req = 1'b0;
    row_pos = '0;
    col_pos = '0;
    kernel_reg = 4'd2;
    stride_reg = 4'd2;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: nothing pools in the first row
    push_pixels(3);
    // extremes of every channel into a 4x2 frame of two 2x2 windows
    setup(2, 2, 4, 2);
    queue_pixel('{16'sh7fff, 16'sh8000, 16'sh0000});
    queue_pixel('{16'sh8000, 16'sh7fff, -16'sd1});
    queue_pixel('{-16'sd1, 16'sh0000, 16'sh7fff});
    queue_pixel('{16'sh8000, 16'sh8000, 16'sh8000});
    queue_pixel('{16'sh0000, -16'sd1, 16'sh8000});
    queue_pixel('{16'sh8000, 16'sh8000, 16'sh8000});
    queue_pixel('{-16'sd1, -16'sd1, -16'sd1});
    queue_pixel('{16'sh8000, 16'sh0001, 16'sh8000});
    pixel_total += 8;
    // zero registers read as one
    setup(0, 0, 0, 0);
    push_pixels(2);
    // oversized kernel saturates
    setup(15, 3, 10, 9);
    push_pixels(4);
    // kernel larger than image: no pooled pixels
    setup(5, 1, 3, 3);
    push_pixels(9);
    // widest settings, short burst only
    setup(1, 15, 2047, 2047);
    push_pixels(40);
    // overlapping windows with the receiver held off
    setup(3, 1, 8, 8);
    quiet_mode = 1'b1;
    hold_req = 1'b1;
    push_pixels(64);
    wait_idle();
    quiet_mode = 1'b0;

    while (pixel_total < 1200) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 2047);
        n = 30;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 12);
        n = w * h * $urandom_range(1, 2) + $urandom_range(0, 3);
      end
      setup(k, s, w, h);
      quiet_mode = ($urandom_range(0, 4) == 0);
      push_pixels(n);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/mp2_pkg.sv
src/mp2_lane.sv
src/mp2_pos.sv
src/max_pool_2d_rgb.sv
tb/testbench.sv
